/* rtl/mme_pkg.sv */
// Shared types, codes and a helper function for the matrix multiply engine.
// Used by mme_ctrl, mme_datapath and matrix_multiply_engine_unit; no dependencies.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int DEFAULT_MAX_DIM = 8;
  localparam int DIM_W           = 4;   // width of a dimension register
  localparam int IDX_W           = 3;   // width of a row or column index
  localparam int ELEM_W          = 16;  // Q8.8 element
  localparam int PROD_W          = 2 * ELEM_W;  // Q16.16 product
  localparam int ACC_W           = 35;  // Q19.16 dot product
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int S_TDATA_W       = 24;
  localparam int M_TDATA_W       = 48;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Item kinds carried on s_tuser.
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_PUSH
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             push;
    logic             push_last;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_status_t;

  // A dimension of zero acts as one, anything above the store size acts as the store size.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] max_d);
    logic [DIM_W-1:0] d;
    d = v;
    if (d == '0) d = DIM_W'(1);
    if (d > max_d) d = max_d;
    return d;
  endfunction

endpackage

/* rtl/mme_ctrl.sv */
// Sequencer of the matrix multiply engine: walks i, j and k for a product run.
// Depends on mme_pkg; drives mme_datapath through dp_cmd_t and reads dp_status_t.
`timescale 1ns / 1ps

module mme_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mme_pkg::KIND_W-1:0]    kind,
  input  logic [mme_pkg::DIM_W-1:0]     dim_n,
  input  logic [mme_pkg::DIM_W-1:0]     dim_p,
  input  logic [mme_pkg::DIM_W-1:0]     dim_m,
  input  mme_pkg::dp_status_t           status,
  output mme_pkg::dp_cmd_t              cmd
);
  import mme_pkg::*;

  ctrl_state_t      state, state_next;
  logic [IDX_W-1:0] i, i_next, j, j_next, k, k_next;
  logic             accept;
  logic             k_end, j_end, i_end;

  assign accept = s_tvalid && s_tready;
  assign k_end  = ({1'b0, k} == dim_p - DIM_W'(1));
  assign j_end  = ({1'b0, j} == dim_m - DIM_W'(1));
  assign i_end  = ({1'b0, i} == dim_n - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_START) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (k_end) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.acc_done) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) state_next = (i_end && j_end) ? ST_IDLE : ST_ISSUE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Loop counters.
  always_comb begin
    i_next = i;
    j_next = j;
    k_next = k;
    case (state)
      ST_IDLE: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
      end
      ST_ISSUE: begin
        if (!k_end) k_next = k + IDX_W'(1);
      end
      ST_PUSH: begin
        if (status.out_free) begin
          k_next = '0;
          if (j_end) begin
            j_next = '0;
            i_next = i + IDX_W'(1);
          end else begin
            j_next = j + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.i         = i;
    cmd.j         = j;
    cmd.k         = k;
    cmd.first     = (k == '0);
    cmd.last_k    = k_end;
    cmd.push_last = i_end && j_end;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.wr_a = accept && kind == KIND_LOAD_A;
        cmd.wr_b = accept && kind == KIND_LOAD_B;
      end
      ST_ISSUE: cmd.rd_en = 1'b1;
      ST_PUSH:  cmd.push  = status.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/mme_datapath.sv */
// Datapath of the matrix multiply engine: A and B stores, one MAC and the result register.
// Depends on mme_pkg; commanded by mme_ctrl.
`timescale 1ns / 1ps

module mme_datapath #(
  parameter int MAX_DIM = mme_pkg::DEFAULT_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mme_pkg::dp_cmd_t                cmd,
  output mme_pkg::dp_status_t             status,
  input  logic [mme_pkg::IDX_W-1:0]       row,
  input  logic [mme_pkg::IDX_W-1:0]       col,
  input  logic signed [mme_pkg::ELEM_W-1:0] elem_value,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mme_pkg::IDX_W-1:0]       out_row,
  output logic [mme_pkg::IDX_W-1:0]       out_col,
  output logic signed [mme_pkg::ACC_W-1:0] product_value,
  output logic                            last
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ELEM_W-1:0]        a_mem [DEPTH];
  logic [ELEM_W-1:0]        b_mem [DEPTH];
  logic [AW-1:0]            wr_addr, a_raddr, b_raddr;
  logic                     wr_ok;
  logic signed [ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, acc_sum;
  logic                     d1_valid, d1_first, d1_last;
  logic                     d2_valid, d2_first, d2_last;
  logic                     acc_done;

  assign wr_ok   = ({1'b0, row} < DIM_W'(MAX_DIM)) && ({1'b0, col} < DIM_W'(MAX_DIM));
  assign wr_addr = AW'(int'(row) * MAX_DIM + int'(col));
  assign a_raddr = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.k));
  assign b_raddr = AW'(int'(cmd.k) * MAX_DIM + int'(cmd.j));

  always_ff @(posedge clk) begin
    if (cmd.wr_a && wr_ok) a_mem[wr_addr] <= elem_value;
    if (cmd.wr_b && wr_ok) b_mem[wr_addr] <= elem_value;
    a_rdata <= a_mem[a_raddr];
    b_rdata <= b_mem[b_raddr];
  end

  // Two-stage MAC: registered product, then accumulate.
  assign acc_sum = (d2_first ? '0 : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod <= a_rdata * b_rdata;
    if (d2_valid) acc <= acc_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      d1_valid <= cmd.rd_en;
      d2_valid <= d1_valid;
      acc_done <= d2_valid && d2_last;
    end
  end

  always_ff @(posedge clk) begin
    d1_first <= cmd.first;
    d1_last  <= cmd.last_k;
    d2_first <= d1_first;
    d2_last  <= d1_last;
  end

  // Result register: a finished element waits here for the downstream side.
  assign status.acc_done = acc_done;
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_row       <= cmd.i;
      out_col       <= cmd.j;
      product_value <= acc;
      last          <= cmd.push_last;
    end
  end

endmodule

/* rtl/matrix_multiply_engine_unit.sv */
// Matrix multiply engine C = A x B over Q8.8 elements with exact Q19.16 dot products.
// A start item yields one result per element of the clamped rows_a by cols_b shape,
// each built by one MAC issue per inner step through the single multiplier, then the
// store read and MAC pipeline, then a hand-off to the result register once it is free.
// Synchronous reset clears the sequencer and result valid and sets all dimensions to 8;
// the A and B stores are not cleared and read as undefined until written.
`timescale 1ns / 1ps

module matrix_multiply_engine_unit #(
  parameter int MAX_DIM = mme_pkg::DEFAULT_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mme_pkg::S_TDATA_W-1:0]     s_tdata,   // row[2:0], col[5:3], elem_value[21:6]
  input  logic [mme_pkg::KIND_W-1:0]        s_tuser,   // kind[1:0]
  // Result items.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mme_pkg::M_TDATA_W-1:0]     m_tdata,   // out_row[2:0], out_col[5:3],
                                                       // product_value[40:6]
  output logic                              m_tlast,
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]         cfg_data
);
  import mme_pkg::*;

  logic [DIM_W-1:0]         rows_a, inner_size, cols_b;
  logic [DIM_W-1:0]         dim_n, dim_p, dim_m;
  dp_cmd_t                  cmd;
  dp_status_t               status;
  logic [IDX_W-1:0]         out_row, out_col;
  logic signed [ACC_W-1:0]  product_value;

  // Dimension registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= DIM_RESET;
      inner_size <= DIM_RESET;
      cols_b     <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:     rows_a     <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the programmed sizes into the range the stores can hold.
  assign dim_n = eff_dim(rows_a, DIM_W'(MAX_DIM));
  assign dim_p = eff_dim(inner_size, DIM_W'(MAX_DIM));
  assign dim_m = eff_dim(cols_b, DIM_W'(MAX_DIM));

  mme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .dim_n    (dim_n),
    .dim_p    (dim_p),
    .dim_m    (dim_m),
    .status   (status),
    .cmd      (cmd)
  );

  mme_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .row           (s_tdata[2:0]),
    .col           (s_tdata[5:3]),
    .elem_value    (s_tdata[21:6]),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last          (m_tlast)
  );

  assign m_tdata = {7'd0, product_value, out_col, out_row};

endmodule

/* tb/matrix_multiply_engine_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine_unit. It loads A and B elements,
// starts products and checks every streamed element against an in-bench Q19.16 model.
// Depends only on mme_pkg and the matrix_multiply_engine_unit RTL.

module matrix_multiply_engine_unit_test;
  import mme_pkg::*;

  localparam int STORE_DIM     = 8;
  localparam int SETTLE_CYCLES = 24;   // more than the longest per-element latency
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 45;

  // Codes the package does not name: the ignored item kind and the unmapped register.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  // One element of the product C as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
  } product_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;   // row[2:0], col[5:3], elem_value[21:6]
  logic [KIND_W-1:0]      s_tuser;   // kind[1:0]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;   // out_row[2:0], out_col[5:3], product_value[40:6]
  logic                   m_tlast;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DIM_W-1:0]       cfg_data;

  // Shadow copy of the block's stores and dimension registers.
  logic signed [ELEM_W-1:0] a_shadow [STORE_DIM*STORE_DIM];
  logic signed [ELEM_W-1:0] b_shadow [STORE_DIM*STORE_DIM];
  bit                       a_loaded [STORE_DIM*STORE_DIM];
  bit                       b_loaded [STORE_DIM*STORE_DIM];
  logic [DIM_W-1:0]         dim_rows  = DIM_RESET;
  logic [DIM_W-1:0]         dim_inner = DIM_RESET;
  logic [DIM_W-1:0]         dim_cols  = DIM_RESET;

  product_t expected_products[$];
  int       failures       = 0;
  int       accepted_items = 0;   // accepted items that the block acts on
  int       src_gap_max    = 0;
  int       sink_gap_max   = 0;
  int       hold_request   = 0;   // nonzero asks the receiver for one long hold-off

  matrix_multiply_engine_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Any fault is counted; only the first ten are described.
  function automatic void note_failure(input string what);
    failures++;
    if (failures <= 10) $display("ERROR at %0t ns: %s", $time, what);
  endfunction

  // A register of zero behaves as one and anything past the store size as the store size.
  function automatic int unsigned shape_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > STORE_DIM) return STORE_DIM;
    return raw;
  endfunction

  // Picks a register value with the given effective size, using the clamped encodings too.
  function automatic logic [DIM_W-1:0] raw_dim(input int unsigned eff);
    if (eff == 1) return DIM_W'($urandom_range(0, 1));
    if (eff == STORE_DIM) return DIM_W'($urandom_range(STORE_DIM, 15));
    return DIM_W'(eff);
  endfunction

  // Element values lean toward the Q8.8 extremes so the exact sums get exercised.
  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Computes every element of C for the current shape and queues it in row-major order.
  function automatic void predict_products();
    int unsigned n;
    int unsigned p;
    int unsigned m;
    longint      sum;
    product_t    elem;
    n = shape_dim(dim_rows);
    p = shape_dim(dim_inner);
    m = shape_dim(dim_cols);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < m; j++) begin
        sum = 0;
        for (int k = 0; k < p; k++) begin
          sum += longint'(a_shadow[i*STORE_DIM + k]) * longint'(b_shadow[k*STORE_DIM + j]);
        end
        elem.row   = IDX_W'(i);
        elem.col   = IDX_W'(j);
        elem.value = sum[ACC_W-1:0];
        elem.last  = (i == n - 1) && (j == m - 1);
        expected_products.push_back(elem);
      end
    end
  endfunction

  // Sends one item after a random gap and updates the shadow state once it is taken.
  // The valid stays high between back-to-back items, so each step sees one assignment.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] value);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, value, col, row};
    do @(posedge clk); while (!s_tready);
    case (kind)
      KIND_LOAD_A: begin
        a_shadow[row*STORE_DIM + col] = value;
        a_loaded[row*STORE_DIM + col] = 1'b1;
      end
      KIND_LOAD_B: begin
        b_shadow[row*STORE_DIM + col] = value;
        b_loaded[row*STORE_DIM + col] = 1'b1;
      end
      KIND_START: predict_products();
      default: ;
    endcase
    if (kind != KIND_UNUSED) accepted_items++;
  endtask

  // Drops valid, waits for every queued product, then lets the pipeline run dry.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three dimension registers; only called while the block is idle.
  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                          input logic [DIM_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_A;
    cfg_data  <= rows;
    dim_rows  = rows;
    @(posedge clk);
    cfg_index <= REG_INNER_SIZE;
    cfg_data  <= inner;
    dim_inner = inner;
    @(posedge clk);
    cfg_index <= REG_COLS_B;
    cfg_data  <= cols;
    dim_cols  = cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Loads every element of the configured shape that is still unwritten, plus a share of
  // the written ones. With noise on, ignored items and stray loads are mixed in as well.
  task automatic load_shape(input int unsigned rewrite_pct, input bit noisy);
    int unsigned n;
    int unsigned p;
    int unsigned m;
    n = shape_dim(dim_rows);
    p = shape_dim(dim_inner);
    m = shape_dim(dim_cols);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < p; k++) begin
        if (!a_loaded[i*STORE_DIM + k] || $urandom_range(0, 99) < rewrite_pct) begin
          if (noisy && $urandom_range(0, 9) == 0) begin
            send_item(KIND_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
          end
          send_item(KIND_LOAD_A, IDX_W'(i), IDX_W'(k), rand_elem());
        end
      end
    end
    for (int k = 0; k < p; k++) begin
      for (int j = 0; j < m; j++) begin
        if (!b_loaded[k*STORE_DIM + j] || $urandom_range(0, 99) < rewrite_pct) begin
          // A stray load may land anywhere, inside the shape or not.
          if (noisy && $urandom_range(0, 9) == 0) begin
            send_item($urandom_range(0, 1) ? KIND_LOAD_A : KIND_LOAD_B,
                      IDX_W'($urandom), IDX_W'($urandom), rand_elem());
          end
          send_item(KIND_LOAD_B, IDX_W'(k), IDX_W'(j), rand_elem());
        end
      end
    end
  endtask

  // A 1x1x1 product at the corners of the Q8.8 range, with an ignored kind and a load
  // outside the configured shape that must not disturb the result.
  task automatic test_single_element();
    wait_idle();
    src_gap_max  = 0;
    sink_gap_max = 0;
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(KIND_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
    send_item(KIND_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_item(KIND_UNUSED, 3'd7, 3'd7, 16'hFFFF);
    send_item(KIND_START, 3'd0, 3'd0, 16'h0000);
    send_item(KIND_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_item(KIND_START, 3'd7, 3'd7, 16'hFFFF);
    send_item(KIND_LOAD_B, 3'd7, 3'd7, 16'h5A5A);
    send_item(KIND_LOAD_B, 3'd0, 3'd0, 16'h0000);
    send_item(KIND_START, 3'd5, 3'd2, 16'h1234);
  endtask

  // Zero in every register acts as one; a write to the unmapped index changes nothing.
  task automatic test_dimension_clamping();
    wait_idle();
    set_dims(4'd0, 4'd0, 4'd0);
    send_item(KIND_START, 3'd0, 3'd0, 16'h0000);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= 4'hF;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_item(KIND_START, 3'd0, 3'd0, 16'h0000);
  endtask

  // The largest possible sum: eight products of -128.0 squared, with inner size 15
  // clamped to the store size.
  task automatic test_longest_dot_product();
    wait_idle();
    src_gap_max  = 16;
    sink_gap_max = 16;
    set_dims(4'd1, 4'd15, 4'd1);
    for (int k = 0; k < STORE_DIM; k++) send_item(KIND_LOAD_A, 3'd0, IDX_W'(k), 16'h8000);
    for (int k = 0; k < STORE_DIM; k++) send_item(KIND_LOAD_B, IDX_W'(k), 3'd0, 16'h8000);
    send_item(KIND_START, 3'd0, 3'd0, 16'h0000);
  endtask

  // The receiver stops for a long stretch while starts and loads keep coming, so the
  // block must fill up and push back on its input.
  task automatic test_output_backpressure();
    wait_idle();
    src_gap_max  = 0;
    sink_gap_max = 4;
    set_dims(4'd2, 4'd2, 4'd2);
    load_shape(0, 1'b0);
    hold_request = HOLD_CYCLES;
    repeat (3) begin
      send_item(KIND_START, 3'd0, 3'd0, 16'h0000);
      load_shape(100, 1'b0);
    end
  endtask

  // Load-then-start sequences on random shapes, mostly small. The second one is pinned to
  // 8x1x8 so every output row and column index appears. Some sequences end without a start
  // and some start twice in a row.
  task automatic test_random_sequences();
    int          base;
    int unsigned seq_count;
    int unsigned n;
    int unsigned p;
    int unsigned m;
    base      = accepted_items;
    seq_count = 0;
    while (accepted_items - base < RANDOM_ITEMS) begin
      wait_idle();
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      if (seq_count == 1) begin
        n = STORE_DIM;
        p = 1;
        m = STORE_DIM;
      end else if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, STORE_DIM);
        p = $urandom_range(1, STORE_DIM);
        m = $urandom_range(1, STORE_DIM);
      end else begin
        n = $urandom_range(1, 3);
        p = $urandom_range(1, 3);
        m = $urandom_range(1, 3);
      end
      set_dims(raw_dim(n), raw_dim(p), raw_dim(m));
      load_shape(25, 1'b1);
      if ($urandom_range(0, 5) != 0) begin
        send_item(KIND_START, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          send_item(KIND_START, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        end
      end
      seq_count++;
    end
  endtask

  // Receiver: each result waits a random number of cycles before ready goes high.
  // A hold request is served at once, even while ready is already up.
  initial begin
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = $urandom_range(0, sink_gap_max);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && hold_request == 0);
    end
  end

  // Every accepted result is matched against the oldest expected product.
  always @(posedge clk) begin
    product_t want;
    product_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.row   = m_tdata[2:0];
      got.col   = m_tdata[5:3];
      got.value = m_tdata[40:6];
      got.last  = m_tlast;
      if (expected_products.size() == 0) begin
        note_failure($sformatf("unexpected product row %0d col %0d value %0h last %0b",
                               got.row, got.col, got.value, got.last));
      end else begin
        want = expected_products.pop_front();
        if (got !== want) begin
          note_failure($sformatf({"product mismatch: expected row %0d col %0d value %0h ",
                                  "last %0b, got row %0d col %0d value %0h last %0b"},
                                 want.row, want.col, want.value, want.last,
                                 got.row, got.col, got.value, got.last));
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_element();
    test_dimension_clamping();
    test_longest_dot_product();
    test_output_backpressure();
    test_random_sequences();

    // All products must be back and nothing further may trickle out.
    wait_idle();
    if (failures == 0) begin
      $display("matrix_multiply_engine_unit_test OK");
    end else begin
      $display("matrix_multiply_engine_unit_test NOT OK");
    end
    $finish;
  end

  // Several times what a correct run needs even if every item were a full 8x8x8 start
  // with the longest gaps on both sides.
  initial begin
    #5_000_000;
    $display("matrix_multiply_engine_unit_test NOT OK");
    $finish;
  end

endmodule
